FILE: hdl/pwts_pkg.sv
// ----------------------------------------------------------------------------
// pwts_pkg
// Shared types and constants of the polynomial tap waveshaper.
// ----------------------------------------------------------------------------
package pwts_pkg;

  // Magnitude format of powers, products and the accumulator (24 fraction bits)
  localparam int unsigned MAG_W   = 62;
  localparam logic [MAG_W-1:0] VAL_LIM = {MAG_W{1'b1}};

  // Q39.16 scale: saturation limit and integer cap of the power loop
  localparam int unsigned SCR_W  = 55;
  localparam logic [SCR_W-1:0] SCALE_LIM = {SCR_W{1'b1}};
  localparam int unsigned POW_W  = 40;
  localparam logic [POW_W-1:0] SCALE_CAP = 40'h80_0000_0000;
  localparam int unsigned SC_W   = 57;

  // Fixed product shifts
  localparam logic [5:0] SH_POW   = 6'd24;
  localparam logic [5:0] SH_SCALE = 6'd16;

  // Configuration register widths and reset values
  localparam int unsigned DRIVE_W = 16;
  localparam int unsigned ORDER_W = 4;
  localparam int unsigned BASE_W  = 5;
  localparam int unsigned EOFF_W  = 4;
  localparam int unsigned SADD_W  = 5;
  localparam int unsigned GAIN_W  = 17;

  localparam logic [DRIVE_W-1:0] DRIVE_RST = 16'd4096;
  localparam logic [ORDER_W-1:0] ORDER_RST = 4'd1;
  localparam logic [BASE_W-1:0]  BASE_RST  = 5'h1F;
  localparam logic [EOFF_W-1:0]  EOFF_RST  = 4'hF;
  localparam logic [SADD_W-1:0]  SADD_RST  = 5'd1;
  localparam logic [GAIN_W-1:0]  GAIN_RST  = 17'd65536;

  // Register indexes (word address)
  localparam logic [2:0] REG_DRIVE = 3'd0;
  localparam logic [2:0] REG_ORDER = 3'd1;
  localparam logic [2:0] REG_BASE  = 3'd2;
  localparam logic [2:0] REG_EOFF  = 3'd3;
  localparam logic [2:0] REG_SADD  = 3'd4;
  localparam logic [2:0] REG_GAIN  = 3'd5;

  // Control of one delay cell
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SC_INIT,
    S_SC_POS,
    S_SC_NEG,
    S_SC_DIV,
    S_SC_SUM,
    S_X_MUL,
    S_P_MUL,
    S_T_MUL,
    S_ACC,
    S_DIV1,
    S_DIV2,
    S_GAIN,
    S_OUT
  } state_e;

endpackage

FILE: hdl/pwts_stream_if.sv
// ----------------------------------------------------------------------------
// pwts_stream_if
// Valid/ready channels for input samples and shaped results.
// ----------------------------------------------------------------------------
interface pwts_in_if #(parameter int SAMPLE_BITS = 24);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] in_sample;

  modport source (output valid, output in_sample, input ready);
  modport sink   (input valid, input in_sample, output ready);
endinterface

interface pwts_out_if #(parameter int SAMPLE_BITS = 24);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic                          clipped;

  modport source (output valid, output out_sample, output clipped, input ready);
  modport sink   (input valid, input out_sample, input clipped, output ready);
endinterface

FILE: hdl/polynomial_tap_waveshaper_top.sv
// ----------------------------------------------------------------------------
// polynomial_tap_waveshaper_top
// Polynomial tap waveshaper: delay-cell chain, serial multiplier and divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input samples arrive on in_if (valid/ready); one beat is one Q1.23 sample.
//   Each accepted beat yields exactly one beat on out_if carrying out_sample
//   and clipped. Registers are to be written over the APB port only while the
//   block is idle; the block does not enforce this. pready is tied high and
//   reads return the register contents. The sample shifts into a chain of
//   delay cells at the accept edge. A sequencer then walks the taps: it forms
//   each tap's scale (a loop over the exponent steps, followed by a division
//   for negative exponents), raises the driven sample to the tap's power on
//   the shared digit-serial multiplier, and accumulates. Two divisions by
//   order+1 and a gain product follow. One sample is in work at a time.
//   The result register frees the sequencer: a new sample is accepted while a
//   result still waits for the receiver. If the receiver stalls the result is
//   held, and a second finished result waits in the sequencer until it drains.
//   Reset clears the delay cells, loads register defaults and empties output.
// ----------------------------------------------------------------------------
module polynomial_tap_waveshaper_top #(
  parameter int MAX_TAPS    = 10,
  parameter int SAMPLE_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pwts_in_if.sink     in_if,
  pwts_out_if.source  out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pwts_pkg::*;

  localparam int JW = $clog2(MAX_TAPS + 1);
  localparam int KW = $clog2(MAX_TAPS + 8);
  localparam int EW = KW + 1;
  localparam int SB = SAMPLE_BITS;
  localparam logic [5:0]    SH_DRIVE = 6'(SAMPLE_BITS - 13);
  localparam logic [5:0]    SH_GAIN  = 6'(41 - SAMPLE_BITS);
  localparam logic [JW-1:0] N_MAX    = JW'(MAX_TAPS);
  localparam logic [MAG_W-1:0] OUT_HALF = MAG_W'(1) << (SAMPLE_BITS - 1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [DRIVE_W-1:0]        drive_q;
  logic [ORDER_W-1:0]        order_q;
  logic signed [BASE_W-1:0]  base_q;
  logic signed [EOFF_W-1:0]  eoff_q;
  logic signed [SADD_W-1:0]  sadd_q;
  logic [GAIN_W-1:0]         gain_q;
  logic                      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_q <= DRIVE_RST;
      order_q <= ORDER_RST;
      base_q  <= BASE_RST;
      eoff_q  <= EOFF_RST;
      sadd_q  <= SADD_RST;
      gain_q  <= GAIN_RST;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_DRIVE: drive_q <= pwdata[DRIVE_W-1:0];
        REG_ORDER: order_q <= pwdata[ORDER_W-1:0];
        REG_BASE:  base_q  <= pwdata[BASE_W-1:0];
        REG_EOFF:  eoff_q  <= pwdata[EOFF_W-1:0];
        REG_SADD:  sadd_q  <= pwdata[SADD_W-1:0];
        REG_GAIN:  gain_q  <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_DRIVE: prdata = 32'(drive_q);
      REG_ORDER: prdata = 32'(order_q);
      REG_BASE:  prdata = 32'($unsigned(base_q));
      REG_EOFF:  prdata = 32'($unsigned(eoff_q));
      REG_SADD:  prdata = 32'($unsigned(sadd_q));
      REG_GAIN:  prdata = 32'(gain_q);
      default:   prdata = '0;
    endcase
  end

  // order above the cell count is taken as the cell count
  logic [JW-1:0] n_cfg;
  assign n_cfg = (int'(order_q) > MAX_TAPS) ? N_MAX : JW'(order_q);

  // --------------------------------------------------------------------------
  // Delay-cell chain: newest sample at position n, cells below shift down
  // --------------------------------------------------------------------------
  state_e state_q, state_d;
  logic   in_acc;
  logic signed [SB-1:0] dl [0:MAX_TAPS];

  assign in_if.ready = (state_q == S_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;

  for (genvar gi = 0; gi <= MAX_TAPS; gi++) begin : g_cell
    cell_ctrl_t ctrl;
    logic signed [SB-1:0] nbr;
    assign ctrl.shift = in_acc && (JW'(gi) < n_cfg);
    assign ctrl.load  = in_acc && (JW'(gi) == n_cfg);
    if (gi < MAX_TAPS) begin : g_nbr
      assign nbr = dl[gi+1];
    end else begin : g_top
      assign nbr = in_if.in_sample;
    end
    pwts_cell #(.W(SB)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .nbr_i  (nbr),
      .smp_i  (in_if.in_sample),
      .q_o    (dl[gi])
    );
  end

  // --------------------------------------------------------------------------
  // Sequencer registers
  // --------------------------------------------------------------------------
  logic [JW-1:0]           n_q;
  logic [JW-1:0]           j_q;
  logic [KW-1:0]           k_q;
  logic signed [EW-1:0]    e_q;
  logic [POW_W-1:0]        m_q;
  logic [SCR_W-1:0]        raw_q;
  logic                    rneg_q;
  logic signed [SC_W-1:0]  sc_q;
  logic signed [MAG_W:0]   x_q;   // drive product, then tap term
  logic signed [MAG_W:0]   p_q;
  logic signed [MAG_W:0]   acc_q;
  logic                    sat_q;
  logic [MAG_W-1:0]        om_q;
  logic                    oneg_q;
  logic                    issued_q;

  logic                    out_valid_q;
  logic signed [SB-1:0]    out_sample_q;
  logic                    out_clip_q;

  // --------------------------------------------------------------------------
  // Shared units
  // --------------------------------------------------------------------------
  logic             mul_start, mul_done, mul_sat, mul_neg;
  logic [MAG_W-1:0] mul_a, mul_b, mul_res;
  logic [5:0]       mul_sh;
  logic             div_start, div_done;
  logic [63:0]      div_num, div_quo;
  logic [31:0]      div_den;

  pwts_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .shift_i (mul_sh),
    .done_o  (mul_done),
    .res_o   (mul_res),
    .sat_o   (mul_sat)
  );

  pwts_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // --------------------------------------------------------------------------
  // Datapath helpers
  // --------------------------------------------------------------------------
  logic signed [SB-1:0]   dl_sel;
  logic [SB-1:0]          dl_mag;
  logic [MAG_W-1:0]       p_mag, x_mag, acc_mag;
  logic [SCR_W-1:0]       sc_mag;
  logic signed [EW-1:0]   e_now;
  logic [KW-1:0]          e_abs;
  logic [BASE_W-1:0]      ab;
  logic [POW_W+4:0]       m_prod;
  logic signed [SC_W:0]   sc_sum, sc_lim;
  logic signed [SC_W-1:0] sc_clamp;
  logic                   sc_over;
  logic                   sc_zero;
  logic signed [MAG_W+1:0] acc_sum, acc_lim;
  logic signed [MAG_W:0]  acc_clamp;
  logic                   acc_over;
  logic signed [MAG_W:0]  res_s;
  logic signed [MAG_W:0]  quo_s;
  logic                   last_tap;
  logic [JW-1:0]          half_n;
  logic                   out_free;
  logic                   o_over;
  logic signed [SB-1:0]   o_val;

  assign dl_sel  = dl[j_q];
  assign dl_mag  = dl_sel[SB-1] ? (~dl_sel + 1'b1) : dl_sel;
  assign p_mag   = p_q[MAG_W] ? MAG_W'(-p_q) : p_q[MAG_W-1:0];
  assign x_mag   = x_q[MAG_W] ? MAG_W'(-x_q) : x_q[MAG_W-1:0];
  assign acc_mag = acc_q[MAG_W] ? MAG_W'(-acc_q) : acc_q[MAG_W-1:0];
  assign sc_mag  = sc_q[SC_W-1] ? SCR_W'(-sc_q) : sc_q[SCR_W-1:0];

  assign e_now  = EW'($signed({1'b0, j_q})) + EW'(eoff_q);
  assign e_abs  = KW'(-e_q);
  assign ab     = base_q[BASE_W-1] ? BASE_W'(-base_q) : $unsigned(base_q);
  assign m_prod = (POW_W+5)'(m_q) * (POW_W+5)'(ab);

  // scale_add*2^16 plus signed power, clamped symmetric
  assign sc_lim   = $signed({2'b0, SCALE_LIM});
  assign sc_sum   = (SC_W+1)'($signed({sadd_q, 16'h0}))
                  + (rneg_q ? -$signed({3'b0, raw_q}) : $signed({3'b0, raw_q}));
  assign sc_over  = (sc_sum > sc_lim) || (sc_sum < -sc_lim);
  assign sc_clamp = (sc_sum > sc_lim) ? SC_W'(sc_lim)
                  : (sc_sum < -sc_lim) ? SC_W'(-sc_lim) : SC_W'(sc_sum);
  assign sc_zero  = (sc_clamp == '0);

  assign acc_lim   = $signed({2'b0, VAL_LIM});
  assign acc_sum   = (MAG_W+2)'(acc_q) + (MAG_W+2)'(x_q);
  assign acc_over  = (acc_sum > acc_lim) || (acc_sum < -acc_lim);
  assign acc_clamp = (acc_sum > acc_lim) ? (MAG_W+1)'(acc_lim)
                   : (acc_sum < -acc_lim) ? (MAG_W+1)'(-acc_lim) : (MAG_W+1)'(acc_sum);

  assign res_s = mul_neg ? -$signed({1'b0, mul_res}) : $signed({1'b0, mul_res});
  assign quo_s = acc_q[MAG_W] ? -$signed(div_quo[MAG_W:0]) : $signed(div_quo[MAG_W:0]);

  assign last_tap = (j_q == n_q);
  assign half_n   = JW'(({1'b0, n_q} + 1'b1) >> 1);

  // output rounding already done; clamp to the sample range
  always_comb begin
    if (oneg_q) begin
      o_over = om_q > OUT_HALF;
      o_val  = o_over ? $signed({1'b1, {(SB-1){1'b0}}}) : SB'(-$signed({1'b0, om_q}));
    end else begin
      o_over = om_q > (OUT_HALF - 1'b1);
      o_val  = o_over ? $signed({1'b0, {(SB-1){1'b1}}}) : SB'(om_q);
    end
  end

  assign out_free = !out_valid_q || out_if.ready;

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = (n_cfg == '0) ? S_DIV1 : S_SC_INIT;
        end
      end
      S_SC_INIT: begin
        if (e_now >= 0) begin
          state_d = S_SC_POS;
        end else if (ab == '0) begin
          state_d = S_SC_SUM;
        end else begin
          state_d = S_SC_NEG;
        end
      end
      S_SC_POS: begin
        if (k_q == KW'(e_q) || ab == '0 || m_prod > (POW_W+5)'(SCALE_CAP)) begin
          state_d = S_SC_SUM;
        end
      end
      S_SC_NEG: begin
        if (k_q == e_abs) begin
          state_d = S_SC_DIV;
        end
      end
      S_SC_DIV: begin
        if (div_done) begin
          state_d = S_SC_SUM;
        end
      end
      S_SC_SUM: begin
        if (!sc_zero) begin
          state_d = S_X_MUL;
        end else begin
          state_d = last_tap ? S_DIV1 : S_SC_INIT;
        end
      end
      S_X_MUL: begin
        if (mul_done) begin
          state_d = (j_q == JW'(1)) ? S_T_MUL : S_P_MUL;
        end
      end
      S_P_MUL: begin
        if (mul_done && k_q == KW'(j_q)) begin
          state_d = S_T_MUL;
        end
      end
      S_T_MUL: begin
        if (mul_done) begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        state_d = last_tap ? S_DIV1 : S_SC_INIT;
      end
      S_DIV1: begin
        if (div_done) begin
          state_d = S_DIV2;
        end
      end
      S_DIV2: begin
        if (div_done) begin
          state_d = S_GAIN;
        end
      end
      S_GAIN: begin
        if (mul_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Unit launch and operand selection
  // --------------------------------------------------------------------------
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    mul_sh    = SH_POW;
    mul_neg   = 1'b0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = 32'd1;
    case (state_q)
      S_X_MUL: begin
        mul_start = !issued_q;
        mul_a     = MAG_W'(drive_q);
        mul_b     = MAG_W'(dl_mag);
        mul_sh    = SH_DRIVE;
        mul_neg   = dl_sel[SB-1];
      end
      S_P_MUL: begin
        mul_start = !issued_q;
        mul_a     = p_mag;
        mul_b     = x_mag;
        mul_sh    = SH_POW;
        mul_neg   = p_q[MAG_W] ^ x_q[MAG_W];
      end
      S_T_MUL: begin
        mul_start = !issued_q;
        mul_a     = p_mag;
        mul_b     = MAG_W'(sc_mag);
        mul_sh    = SH_SCALE;
        mul_neg   = p_q[MAG_W] ^ sc_q[SC_W-1];
      end
      S_GAIN: begin
        mul_start = !issued_q;
        mul_a     = acc_mag;
        mul_b     = MAG_W'(gain_q);
        mul_sh    = SH_GAIN;
      end
      S_SC_DIV: begin
        div_start = !issued_q;
        div_num   = 64'd65536 + 64'(m_q >> 1);
        div_den   = 32'(m_q);
      end
      S_DIV1, S_DIV2: begin
        div_start = !issued_q;
        div_num   = 64'(acc_mag) + 64'(half_n);
        div_den   = 32'(n_q) + 32'd1;
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mul_start || div_start) begin
        issued_q <= 1'b1;
      end else if (mul_done || div_done) begin
        issued_q <= 1'b0;
      end
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // hold the result beat until the receiver takes it
  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      out_sample_q <= o_val;
      out_clip_q   <= sat_q | o_over;
    end
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.out_sample = out_sample_q;
  assign out_if.clipped    = out_clip_q;

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          n_q   <= n_cfg;
          j_q   <= JW'(1);
          acc_q <= '0;
          sat_q <= 1'b0;
        end
      end
      S_SC_INIT: begin
        e_q    <= e_now;
        m_q    <= POW_W'(1);
        k_q    <= '0;
        // zero base with negative exponent: positive scale maximum
        if (e_now < 0 && ab == '0) begin
          raw_q  <= SCALE_LIM;
          rneg_q <= 1'b0;
          sat_q  <= 1'b1;
        end else begin
          rneg_q <= base_q[BASE_W-1] & e_now[0];
        end
      end
      S_SC_POS: begin
        if (k_q == KW'(e_q)) begin
          if (m_q == SCALE_CAP) begin
            raw_q <= SCALE_LIM;
            sat_q <= 1'b1;
          end else begin
            raw_q <= SCR_W'({m_q, 16'h0});
          end
        end else if (ab == '0) begin
          raw_q <= '0;
        end else if (m_prod > (POW_W+5)'(SCALE_CAP)) begin
          raw_q <= SCALE_LIM;
          sat_q <= 1'b1;
        end else begin
          m_q <= m_prod[POW_W-1:0];
          k_q <= k_q + 1'b1;
        end
      end
      S_SC_NEG: begin
        if (k_q != e_abs) begin
          m_q <= m_prod[POW_W-1:0];
          k_q <= k_q + 1'b1;
        end
      end
      S_SC_DIV: begin
        if (div_done) begin
          raw_q <= SCR_W'(div_quo);
        end
      end
      S_SC_SUM: begin
        sc_q <= sc_clamp;
        if (sc_over) begin
          sat_q <= 1'b1;
        end
        if (sc_zero && !last_tap) begin
          j_q <= j_q + 1'b1;
        end
      end
      S_X_MUL: begin
        if (mul_done) begin
          x_q   <= res_s;
          p_q   <= res_s;
          sat_q <= sat_q | mul_sat;
          k_q   <= KW'(2);
        end
      end
      S_P_MUL: begin
        if (mul_done) begin
          p_q   <= res_s;
          sat_q <= sat_q | mul_sat;
          k_q   <= k_q + 1'b1;
        end
      end
      S_T_MUL: begin
        if (mul_done) begin
          x_q   <= res_s;
          sat_q <= sat_q | mul_sat;
        end
      end
      S_ACC: begin
        acc_q <= acc_clamp;
        sat_q <= sat_q | acc_over;
        if (!last_tap) begin
          j_q <= j_q + 1'b1;
        end
      end
      S_DIV1, S_DIV2: begin
        if (div_done) begin
          acc_q <= quo_s;
        end
      end
      S_GAIN: begin
        if (mul_done) begin
          om_q   <= mul_res;
          oneg_q <= acc_q[MAG_W];
          sat_q  <= sat_q | mul_sat;
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  ap_mul_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == S_X_MUL || state_q == S_P_MUL ||
                  state_q == S_T_MUL || state_q == S_GAIN))
    else $error("multiplier finished outside a product state");

  ap_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_SC_DIV || state_q == S_DIV1 || state_q == S_DIV2))
    else $error("divider finished outside a division state");

  ap_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != S_IDLE)
    else $error("sample accepted but sequencer stayed idle");

  ap_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_OUT)
    else $error("result beat raised without a finished sample");

  ap_tap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SC_INIT |-> (j_q != '0 && j_q <= n_q))
    else $error("tap index outside the active order");

endmodule

FILE: hdl/pwts_cell.sv
// ----------------------------------------------------------------------------
// pwts_cell
// One delay-line cell: loads a new sample or takes its upper neighbor's word.
// ----------------------------------------------------------------------------
module pwts_cell #(
  parameter int W = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pwts_pkg::cell_ctrl_t ctrl_i,
  input  logic signed [W-1:0] nbr_i,
  input  logic signed [W-1:0] smp_i,
  output logic signed [W-1:0] q_o
);
  import pwts_pkg::*;

  logic signed [W-1:0] val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else if (ctrl_i.load) begin
      val_q <= smp_i;
    end else if (ctrl_i.shift) begin
      val_q <= nbr_i;
    end
  end

  assign q_o = val_q;

endmodule

FILE: hdl/pwts_mul.sv
// ----------------------------------------------------------------------------
// pwts_mul
// Digit-serial magnitude multiplier with round-half-up shift and saturation.
// ----------------------------------------------------------------------------
module pwts_mul (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [pwts_pkg::MAG_W-1:0] a_i,
  input  logic [pwts_pkg::MAG_W-1:0] b_i,
  input  logic [5:0]                 shift_i,
  output logic                       done_o,
  output logic [pwts_pkg::MAG_W-1:0] res_o,
  output logic                       sat_o
);
  import pwts_pkg::*;

  localparam int DW  = 16;
  localparam int BW  = 64;
  localparam int PW  = 2 * MAG_W + 1;
  localparam int PPW = MAG_W + DW;

  logic [MAG_W-1:0] a_q;
  logic [BW-1:0]    b_q;
  logic [5:0]       sh_q;
  logic [PW-1:0]    acc_q;
  logic [1:0]       cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [PPW-1:0]   pp;
  logic [PW-1:0]    pp_sh;
  logic [PW-1:0]    shr;

  // one 62x16 partial product per cycle, lowest digit first
  assign pp    = PPW'(a_q) * PPW'(b_q[{cnt_q, 4'b0} +: DW]);
  assign pp_sh = PW'(pp) << {cnt_q, 4'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 2'd3);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // rounding constant preloaded into the accumulator
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= BW'(b_i);
      sh_q  <= shift_i;
      acc_q <= PW'(1) << (shift_i - 6'd1);
    end else if (busy_q) begin
      acc_q <= acc_q + pp_sh;
    end
  end

  assign shr    = acc_q >> sh_q;
  assign sat_o  = |shr[PW-1:MAG_W];
  assign res_o  = sat_o ? VAL_LIM : shr[MAG_W-1:0];
  assign done_o = done_q;

endmodule

FILE: hdl/pwts_div.sv
// ----------------------------------------------------------------------------
// pwts_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pwts_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [63:0] quo_o
);
  import pwts_pkg::*;

  logic [63:0] q_q;
  logic [31:0] rem_q;
  logic [31:0] den_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic        done_q;

  logic [32:0] trial;
  logic        ge;
  logic [32:0] diff;

  assign trial = {rem_q, q_q[63]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 6'd63);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[31:0] : trial[31:0];
      q_q   <= {q_q[62:0], ge};
    end
  end

  assign quo_o  = q_q;
  assign done_o = done_q;

endmodule

FILE: tb/polynomial_tap_waveshaper_top_tb.sv
// ----------------------------------------------------------------------------
// polynomial_tap_waveshaper_top_tb
// Self-checking bench for the polynomial tap waveshaper. Samples are driven on
// the input channel and a bit-exact shaper model predicts every result beat.
// Registers are set over APB between phases while the block is drained.
// ----------------------------------------------------------------------------
module polynomial_tap_waveshaper_top_tb;
  import pwts_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SBITS      = 24;
  localparam int NTAPS      = 10;
  localparam int SETTLE     = 1300;   // drain wait for the sequencer to go idle
  localparam int STALL_LIM  = 20000;  // cycles without any beat or write
  localparam logic [2:0] REG_NONE_A = 3'd6;
  localparam logic [2:0] REG_NONE_B = 3'd7;
  localparam logic [63:0] MAG_LIM   = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SCL_LIM   = 64'h007F_FFFF_FFFF_FFFF;
  localparam logic [63:0] SCL_CAP   = 64'h80_0000_0000;

  typedef struct {
    logic signed [SBITS-1:0] smp;
    logic                    clip;
  } shaped_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  pwts_in_if  #(.SAMPLE_BITS(SBITS)) in_if ();
  pwts_out_if #(.SAMPLE_BITS(SBITS)) out_if ();

  polynomial_tap_waveshaper_top #(.MAX_TAPS(NTAPS), .SAMPLE_BITS(SBITS)) uut (
    .clk_i, .rst_ni, .in_if(in_if.sink), .out_if(out_if.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Register shadow, delay line and pending results of the shaper model
  logic [DRIVE_W-1:0]        sh_drive;
  logic [ORDER_W-1:0]        sh_order;
  logic signed [BASE_W-1:0]  sh_base;
  logic signed [EOFF_W-1:0]  sh_eoff;
  logic signed [SADD_W-1:0]  sh_sadd;
  logic [GAIN_W-1:0]         sh_gain;
  longint                    hist [0:NTAPS];
  shaped_t                   shaped_q [$];
  bit                        clip_seen;
  int                        errors = 0;

  // Idle percentages and the long receiver freeze request
  int  tx_idle_pct = 0;
  int  rx_idle_pct = 0;
  bit  rx_freeze_req = 0;
  int  rx_freeze_left = 0;

  function automatic logic [63:0] umag(longint a);
    return (a < 0) ? -a : a;
  endfunction

  // round(a*b / 2^s) on magnitudes, saturated at lim
  function automatic logic [63:0] mag_mul(logic [63:0] a, logic [63:0] b, int s,
                                          logic [63:0] lim);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = (p + (128'd1 << (s - 1))) >> s;
    if (p > {64'd0, lim}) begin
      clip_seen = 1'b1;
      return lim;
    end
    return p[63:0];
  endfunction

  function automatic longint smul(longint a, longint b, int s, logic [63:0] lim);
    longint m;
    m = longint'(mag_mul(umag(a), umag(b), s, lim));
    return ((a < 0) != (b < 0)) ? -m : m;
  endfunction

  function automatic longint div_near(longint a, longint n);
    longint m;
    m = longint'((umag(a) + n / 2) / n);
    return (a < 0) ? -m : m;
  endfunction

  function automatic longint clamp_sym(longint v, longint lim);
    if (v > lim) begin
      clip_seen = 1'b1;
      return lim;
    end
    if (v < -lim) begin
      clip_seen = 1'b1;
      return -lim;
    end
    return v;
  endfunction

  // Q39.16 scale of one tap for exponent e
  function automatic longint tap_weight(int e);
    longint b, ab, d, pw;
    logic [63:0] m, raw;
    bit neg;
    b   = sh_base;
    ab  = umag(b);
    neg = (b < 0) && (umag(e) % 2 == 1);
    if (e >= 0) begin
      m = 1;
      for (int k = 0; k < e; k++) begin
        if (ab == 0) begin
          m = 0;
          break;
        end
        if (m > SCL_CAP / ab) begin
          m = SCL_CAP;
          clip_seen = 1'b1;
          break;
        end
        m = m * ab;
      end
      raw = m << 16;
      if (raw > SCL_LIM) begin
        raw = SCL_LIM;
        clip_seen = 1'b1;
      end
    end else if (ab == 0) begin
      raw = SCL_LIM;
      neg = 0;
      clip_seen = 1'b1;
    end else begin
      d = 1;
      for (int k = 0; k < -e; k++) d = d * ab;
      raw = (65536 + d / 2) / d;
    end
    pw = neg ? -longint'(raw) : longint'(raw);
    return clamp_sym(longint'(sh_sadd) * 65536 + pw, longint'(SCL_LIM));
  endfunction

  // Shift one sample in and work out the shaped result
  function automatic shaped_t shape_sample(logic signed [SBITS-1:0] smp);
    shaped_t r;
    int      n;
    longint  acc, sc, x, p, o;
    clip_seen = 1'b0;
    n = (sh_order > NTAPS) ? NTAPS : sh_order;
    for (int j = 0; j < n; j++) hist[j] = hist[j + 1];
    hist[n] = smp;
    acc = 0;
    for (int j = 1; j <= n; j++) begin
      sc = tap_weight(j + sh_eoff);
      if (sc == 0) continue;
      x = smul(longint'(sh_drive), hist[j], SBITS - 13, MAG_LIM);
      p = x;
      for (int k = 2; k <= j; k++) p = smul(p, x, 24, MAG_LIM);
      acc = clamp_sym(acc + smul(p, sc, 16, MAG_LIM), longint'(MAG_LIM));
    end
    acc = div_near(acc, n + 1);
    acc = div_near(acc, n + 1);
    o = smul(acc, longint'(sh_gain), 41 - SBITS, MAG_LIM);
    if (o > 64'sd8388607) begin
      o = 8388607;
      clip_seen = 1'b1;
    end
    if (o < -64'sd8388608) begin
      o = -8388608;
      clip_seen = 1'b1;
    end
    r.smp  = o[SBITS-1:0];
    r.clip = clip_seen;
    return r;
  endfunction

  // Track register writes and accepted samples; predict at the accept edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sh_drive <= DRIVE_RST;
      sh_order <= ORDER_RST;
      sh_base  <= BASE_RST;
      sh_eoff  <= EOFF_RST;
      sh_sadd  <= SADD_RST;
      sh_gain  <= GAIN_RST;
      for (int i = 0; i <= NTAPS; i++) hist[i] = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_DRIVE: sh_drive <= pwdata[DRIVE_W-1:0];
          REG_ORDER: sh_order <= pwdata[ORDER_W-1:0];
          REG_BASE:  sh_base  <= pwdata[BASE_W-1:0];
          REG_EOFF:  sh_eoff  <= pwdata[EOFF_W-1:0];
          REG_SADD:  sh_sadd  <= pwdata[SADD_W-1:0];
          REG_GAIN:  sh_gain  <= pwdata[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) shaped_q.push_back(shape_sample(in_if.in_sample));
    end
  end

  // Compare every result beat with the oldest prediction
  always @(posedge clk_i) begin
    shaped_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (shaped_q.size() == 0) begin
        $error("result beat with no sample pending: out_sample=%0d clipped=%0b",
               out_if.out_sample, out_if.clipped);
        errors++;
      end else begin
        want = shaped_q.pop_front();
        if (out_if.out_sample !== want.smp) begin
          $error("out_sample: expected %0d, got %0d", want.smp, out_if.out_sample);
          errors++;
        end
        if (out_if.clipped !== want.clip) begin
          $error("clipped: expected %0b, got %0b", want.clip, out_if.clipped);
          errors++;
        end
      end
    end
  end

  // Receiver: random stalls, plus a long freeze when requested
  always @(posedge clk_i) begin
    if (rx_freeze_req) begin
      rx_freeze_left = 600;
      rx_freeze_req  = 0;
    end
    if (rx_freeze_left > 0) begin
      rx_freeze_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog: count cycles in which nothing moves
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (psel && penable) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIM) begin
      $display("polynomial_tap_waveshaper_top regression: fail");
      $finish;
    end
  end

  // Offer one sample, hold until accepted, then maybe drop valid for a random pause
  task automatic send_sample(logic signed [SBITS-1:0] smp);
    in_if.valid     <= 1'b1;
    in_if.in_sample <= smp;
    do @(posedge clk_i); while (!in_if.ready);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Drop valid, wait for every result, then let the sequencer settle
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (shaped_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_shape(logic [15:0] drv, logic [3:0] ord, logic [4:0] base,
                           logic [3:0] eoff, logic [4:0] sadd, logic [16:0] gain);
    reg_write(REG_DRIVE, drv);
    reg_write(REG_ORDER, ord);
    reg_write(REG_BASE, base);
    reg_write(REG_EOFF, eoff);
    reg_write(REG_SADD, sadd);
    reg_write(REG_GAIN, gain);
  endtask

  // Mostly small orders keep the sequencer fast; a few go past the tap limit
  function automatic logic [3:0] pick_order();
    return ($urandom_range(99) < 80) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(4, 15));
  endfunction

  function automatic logic signed [SBITS-1:0] pick_sample();
    case ($urandom_range(5))
      0:       return 24'sh7FFFFF;
      1:       return 24'sh800000;
      2:       return 24'($signed(16'($urandom())));
      default: return 24'($urandom());
    endcase
  endfunction

  task automatic shape_random();
    set_shape(($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 8192)),
              pick_order(), 5'($urandom()), 4'($urandom()), 5'($urandom()),
              ($urandom_range(3) == 0) ? 17'($urandom()) : 17'($urandom_range(0, 65536)));
  endtask

  // Defaults after reset, with sample extremes
  task automatic test_defaults();
    send_sample(24'sh000000);
    send_sample(24'sh7FFFFF);
    send_sample(24'sh800000);
    send_sample(-24'sd1);
    send_sample(24'sd1);
    send_sample(24'sh555555);
    send_sample(24'shAAAAAA);
    drain();
  endtask

  // Corner settings: each special case gets one to three samples
  task automatic test_corners();
    // order zero: nothing summed
    set_shape(16'd40960, 4'd0, 5'd3, 4'd0, 5'd1, 17'd65536);
    send_sample(24'sh7FFFFF);
    send_sample(24'sh800000);
    drain();
    // order past the tap limit, strong drive and a large base
    set_shape(16'hFFFF, 4'd15, 5'd10, 4'd5, 5'h16, 17'h1FFFF);
    send_sample(24'sh7FFFFF);
    send_sample(24'sh800000);
    send_sample(24'sd1234);
    drain();
    // zero base with negative exponents saturates the scale
    set_shape(16'd4096, 4'd3, 5'd0, 4'hB, 5'd0, 17'd65536);
    send_sample(24'sh400000);
    send_sample(-24'sd77);
    drain();
    // zero scale skips every tap (1 + (-1)^e with odd exponents)
    set_shape(16'd4096, 4'd1, 5'h1F, 4'd0, 5'd1, 17'd65536);
    send_sample(24'sh7FFFFF);
    drain();
    // zero drive, zero gain, negative base with fractional scale
    set_shape(16'd0, 4'd2, 5'h16, 4'hC, 5'h10, 17'd0);
    send_sample(24'sh123456);
    drain();
    reg_write(REG_DRIVE, 32'd12345);
    send_sample(24'sh7FFFFF);
    drain();
    // writes beyond the register list are ignored; order changes keep stale taps
    reg_write(REG_NONE_A, 32'hFFFF_FFFF);
    reg_write(REG_NONE_B, 32'h0);
    reg_write(REG_ORDER, 32'd10);
    send_sample(24'sh654321);
    send_sample(24'sh800000);
    drain();
    reg_write(REG_ORDER, 32'd2);
    reg_write(REG_GAIN, 32'd65536);
    send_sample(24'sh0F0F0F);
    drain();
  endtask

  // Random settings and samples under one idle mix
  task automatic test_random(int tx_pct, int rx_pct, int beats);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int i = 0; i < beats; i++) begin
      if (i % 40 == 0) begin
        drain();
        shape_random();
      end
      send_sample(pick_sample());
    end
    drain();
  endtask

  // Freeze the receiver while samples keep coming, so the block backs up
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_shape(16'd4096, 4'd0, 5'd2, 4'd0, 5'd1, 17'd65536);
    rx_freeze_req = 1;
    repeat (8) send_sample(pick_sample());
    drain();
  endtask

  // Pause the sender until every result is back, then resume
  task automatic test_sender_pause();
    shape_random();
    repeat (5) send_sample(pick_sample());
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (shaped_q.size() != 0) @(posedge clk_i);
    repeat (5) send_sample(pick_sample());
    drain();
  endtask

  initial begin
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_if.valid     = 1'b0;
    in_if.in_sample = '0;
    out_if.ready    = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_defaults();
    test_corners();
    test_backpressure();
    test_sender_pause();
    test_random(21, 59, 360);
    test_random(59, 21, 360);
    test_random(0, 0, 360);

    if (errors == 0)
      $display("polynomial_tap_waveshaper_top regression: pass");
    else
      $display("polynomial_tap_waveshaper_top regression: fail");
    $finish;
  end

endmodule
